// ===== design/mrpr_pkg.sv =====
// shared types and constants for the multi-region pixel router
`default_nettype none

package mrpr_pkg;

   localparam int CHANNEL_WIDTH      = 16;
   localparam int COORD_WIDTH        = 16;
   localparam int MASK_WIDTH         = 4;
   localparam int REGION_COUNT_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH     = 64;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_REGION_COUNT = 3'd2,
      CSR_REGION_ZERO  = 3'd3,
      CSR_REGION_ONE   = 3'd4,
      CSR_REGION_TWO   = 3'd5,
      CSR_REGION_THREE = 3'd6
   } csr_index_type;

   // packed from high to low as width, height, x, y
   typedef struct packed {
      logic [COORD_WIDTH-1:0] w;
      logic [COORD_WIDTH-1:0] h;
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
   } region_type;

   typedef struct packed {
      logic [CHANNEL_WIDTH-1:0] red;
      logic [CHANNEL_WIDTH-1:0] green;
      logic [CHANNEL_WIDTH-1:0] blue;
      logic [CHANNEL_WIDTH-1:0] alpha;
   } pixel_type;

endpackage

`default_nettype wire

// ===== design/multi_region_pixel_router.sv =====
// top level of the multi-region pixel router
//
// Takes one RGBA pixel per cycle in raster order and tracks its column and
// row against the configured frame size. Each pixel is tested against the
// first region_count rectangles (at most NUM_REGIONS) and is forwarded with
// the mask of the rectangles that hold it; pixels that fall in no rectangle
// are dropped. A pixel is captured with its position in an input register,
// the rectangle compares run in parallel behind it, and a result register
// holds the outgoing transaction; the sustained rate is one pixel per
// cycle while rsp_ready is high. req_ready follows rsp_ready
// combinationally through the two stages. Configuration writes take effect
// at once and should be made while no transaction is in flight.
`default_nettype none

module multi_region_pixel_router import mrpr_pkg::*; #(
   parameter int NUM_REGIONS = 4
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [CHANNEL_WIDTH-1:0]      req_red_in,
   input  logic [CHANNEL_WIDTH-1:0]      req_green_in,
   input  logic [CHANNEL_WIDTH-1:0]      req_blue_in,
   input  logic [CHANNEL_WIDTH-1:0]      req_alpha_in,

   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [CHANNEL_WIDTH-1:0]      rsp_red_out,
   output logic [CHANNEL_WIDTH-1:0]      rsp_green_out,
   output logic [CHANNEL_WIDTH-1:0]      rsp_blue_out,
   output logic [CHANNEL_WIDTH-1:0]      rsp_alpha_out,
   output logic [MASK_WIDTH-1:0]         rsp_region_mask,

   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // configuration
   logic [COORD_WIDTH-1:0]        image_width_ff;
   logic [COORD_WIDTH-1:0]        image_height_ff;
   logic [REGION_COUNT_WIDTH-1:0] region_count_ff;
   region_type                    region_ff [NUM_REGIONS];

   // position of the next pixel
   logic [COORD_WIDTH-1:0]        col_ff, col_in;
   logic [COORD_WIDTH-1:0]        row_ff, row_in;
   logic [COORD_WIDTH:0]          col_inc;
   logic [COORD_WIDTH:0]          row_inc;

   // input stage
   logic                          s1_valid_ff, s1_valid_in;
   pixel_type                     s1_pixel_ff;
   logic [COORD_WIDTH-1:0]        s1_col_ff;
   logic [COORD_WIDTH-1:0]        s1_row_ff;

   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   pixel_type                     rsp_pixel_ff;
   logic [MASK_WIDTH-1:0]         rsp_mask_ff;

   logic [MASK_WIDTH-1:0]         match_mask;
   logic                          out_free;
   logic                          s1_advance;
   logic                          rsp_load;
   logic                          req_take;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= '0;
         image_height_ff <= '0;
         region_count_ff <= '0;
         for (int i = 0; i < NUM_REGIONS; i++) begin
            region_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_IMAGE_WIDTH) begin
            image_width_ff <= csr_wdata[COORD_WIDTH-1:0];
         end
         if (csr_index == CSR_IMAGE_HEIGHT) begin
            image_height_ff <= csr_wdata[COORD_WIDTH-1:0];
         end
         if (csr_index == CSR_REGION_COUNT) begin
            region_count_ff <= csr_wdata[REGION_COUNT_WIDTH-1:0];
         end
         for (int i = 0; i < NUM_REGIONS; i++) begin
            if (csr_index == CSR_REGION_ZERO + CSR_INDEX_WIDTH'(i)) begin
               region_ff[i] <= region_type'(csr_wdata);
            end
         end
      end
   end

   // handshake between stages
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_advance = s1_valid_ff && ((match_mask == '0) || out_free);
   assign rsp_load   = s1_advance && (match_mask != '0);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // raster position counters
   assign col_inc = {1'b0, col_ff} + (COORD_WIDTH+1)'(1);
   assign row_inc = {1'b0, row_ff} + (COORD_WIDTH+1)'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_take) begin
         if (col_inc >= {1'b0, image_width_ff}) begin
            col_in = '0;
            if (row_inc >= {1'b0, image_height_ff}) begin
               row_in = '0;
            end else begin
               row_in = row_inc[COORD_WIDTH-1:0];
            end
         end else begin
            col_in = col_inc[COORD_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= '{red: req_red_in, green: req_green_in,
                          blue: req_blue_in, alpha: req_alpha_in};
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
      end
      if (rsp_load) begin
         rsp_pixel_ff <= s1_pixel_ff;
         rsp_mask_ff  <= match_mask;
      end
   end

   mrpr_match #(
      .NUM_REGIONS (NUM_REGIONS)
   ) u_match (
      .col          (s1_col_ff),
      .row          (s1_row_ff),
      .region_count (region_count_ff),
      .regions      (region_ff),
      .mask         (match_mask)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_out     = rsp_pixel_ff.red;
   assign rsp_green_out   = rsp_pixel_ff.green;
   assign rsp_blue_out    = rsp_pixel_ff.blue;
   assign rsp_alpha_out   = rsp_pixel_ff.alpha;
   assign rsp_region_mask = rsp_mask_ff;

endmodule

`default_nettype wire

// ===== design/mrpr_match.sv =====
// parallel rectangle containment test producing the region mask
`default_nettype none

module mrpr_match import mrpr_pkg::*; #(
   parameter int NUM_REGIONS = 4
) (
   input  logic [COORD_WIDTH-1:0]        col,
   input  logic [COORD_WIDTH-1:0]        row,
   input  logic [REGION_COUNT_WIDTH-1:0] region_count,
   input  region_type                    regions [NUM_REGIONS],
   output logic [MASK_WIDTH-1:0]         mask
);

   for (genvar i = 0; i < MASK_WIDTH; i++) begin : g_region
      if (i < NUM_REGIONS) begin : g_used
         logic [COORD_WIDTH:0] x_end;
         logic [COORD_WIDTH:0] y_end;
         logic                 active;
         logic                 contained;

         // end coordinates one bit wider so they never wrap
         assign x_end  = {1'b0, regions[i].x} + {1'b0, regions[i].w};
         assign y_end  = {1'b0, regions[i].y} + {1'b0, regions[i].h};
         assign active = region_count > REGION_COUNT_WIDTH'(i);
         assign contained = (col >= regions[i].x) && ({1'b0, col} < x_end) &&
                            (row >= regions[i].y) && ({1'b0, row} < y_end);
         assign mask[i] = active && contained;
      end else begin : g_unused
         assign mask[i] = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== design/mrpr_checker.sv =====
// port-level checks for the multi-region pixel router and their bind
`default_nettype none

module mrpr_checker import mrpr_pkg::*; #(
   parameter int NUM_REGIONS = 4
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [CHANNEL_WIDTH-1:0] rsp_red_out,
   input logic [CHANNEL_WIDTH-1:0] rsp_green_out,
   input logic [CHANNEL_WIDTH-1:0] rsp_blue_out,
   input logic [CHANNEL_WIDTH-1:0] rsp_alpha_out,
   input logic [MASK_WIDTH-1:0]    rsp_region_mask
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_red_out) &&
         $stable(rsp_green_out) && $stable(rsp_blue_out) &&
         $stable(rsp_alpha_out) && $stable(rsp_region_mask))
      else $error("result transaction changed while stalled");

   // only pixels inside some rectangle come out
   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_region_mask != '0)
      else $error("result with empty region mask");

   // no mask bit for a rectangle that does not exist
   a_mask_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_region_mask >> NUM_REGIONS) == '0)
      else $error("region mask bit beyond configured regions");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an idle input stage always takes a transaction
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!req_valid) && !$past(reset) |-> req_ready)
      else $error("input stalled with empty pipeline");

endmodule

bind multi_region_pixel_router mrpr_checker #(
   .NUM_REGIONS (NUM_REGIONS)
) u_mrpr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_red_out     (rsp_red_out),
   .rsp_green_out   (rsp_green_out),
   .rsp_blue_out    (rsp_blue_out),
   .rsp_alpha_out   (rsp_alpha_out),
   .rsp_region_mask (rsp_region_mask)
);

`default_nettype wire

// ===== tb/tb.sv =====
// testbench for the multi-region pixel router
module tb;
   import mrpr_pkg::*;

   localparam int NUM_REGIONS   = 4;
   localparam int RANDOM_PIXELS = 900;
   localparam int DRAIN_CYCLES  = 8;
   localparam int CYCLE_LIMIT   = 400000;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      pixel_type              px;
      logic [MASK_WIDTH-1:0]  mask;
   } route_entry_t;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [CHANNEL_WIDTH-1:0]   req_red_in = '0;
   logic [CHANNEL_WIDTH-1:0]   req_green_in = '0;
   logic [CHANNEL_WIDTH-1:0]   req_blue_in = '0;
   logic [CHANNEL_WIDTH-1:0]   req_alpha_in = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [CHANNEL_WIDTH-1:0]   rsp_red_out;
   logic [CHANNEL_WIDTH-1:0]   rsp_green_out;
   logic [CHANNEL_WIDTH-1:0]   rsp_blue_out;
   logic [CHANNEL_WIDTH-1:0]   rsp_alpha_out;
   logic [MASK_WIDTH-1:0]      rsp_region_mask;
   logic                       csr_write_en = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   logic [COORD_WIDTH-1:0]        frame_width = '0;
   logic [COORD_WIDTH-1:0]        frame_height = '0;
   logic [REGION_COUNT_WIDTH-1:0] region_limit = '0;
   region_type                    region_table [4] = '{default: '0};
   logic [COORD_WIDTH-1:0]        col_pos = '0;
   logic [COORD_WIDTH-1:0]        row_pos = '0;

   pixel_type    pixel_backlog [$];
   route_entry_t pending_routes [$];
   pixel_type    offered_px;
   int           send_wait = 0;
   int           recv_wait = 0;
   bit           send_burst = 1'b0;
   bit           recv_burst = 1'b0;
   int           fault_count = 0;
   int           cycle_count = 0;

   multi_region_pixel_router #(.NUM_REGIONS(NUM_REGIONS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .req_alpha_in    (req_alpha_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_alpha_out   (rsp_alpha_out),
      .rsp_region_mask (rsp_region_mask),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic void predict_route(pixel_type px);
      logic [MASK_WIDTH-1:0]  hits;
      logic [COORD_WIDTH:0]   x_end;
      logic [COORD_WIDTH:0]   y_end;
      logic [COORD_WIDTH:0]   next_pos;
      region_type             r;
      int                     active;
      int                     i;
      hits = '0;
      active = (region_limit > NUM_REGIONS) ? NUM_REGIONS : int'(region_limit);
      for (i = 0; i < active; i++) begin
         r = region_table[i];
         x_end = {1'b0, r.x} + {1'b0, r.w};
         y_end = {1'b0, r.y} + {1'b0, r.h};
         if (r.x <= col_pos && {1'b0, col_pos} < x_end &&
             r.y <= row_pos && {1'b0, row_pos} < y_end)
            hits[i] = 1'b1;
      end
      next_pos = {1'b0, col_pos} + 17'd1;
      if (next_pos >= {1'b0, frame_width}) begin
         col_pos = '0;
         next_pos = {1'b0, row_pos} + 17'd1;
         if (next_pos >= {1'b0, frame_height})
            row_pos = '0;
         else
            row_pos = next_pos[COORD_WIDTH-1:0];
      end else begin
         col_pos = next_pos[COORD_WIDTH-1:0];
      end
      if (hits != '0)
         pending_routes.push_back('{px, hits});
   endfunction

   task automatic write_register(logic [CSR_INDEX_WIDTH-1:0] idx,
                                 logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      case (idx)
         CSR_IMAGE_WIDTH:  frame_width = data[COORD_WIDTH-1:0];
         CSR_IMAGE_HEIGHT: frame_height = data[COORD_WIDTH-1:0];
         CSR_REGION_COUNT: region_limit = data[REGION_COUNT_WIDTH-1:0];
         CSR_REGION_ZERO:  region_table[0] = data;
         CSR_REGION_ONE:   region_table[1] = data;
         CSR_REGION_TWO:   region_table[2] = data;
         CSR_REGION_THREE: region_table[3] = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_pixels(int count, bit patterned);
      logic [CHANNEL_WIDTH-1:0] tone;
      int                       k;
      @(negedge clock);
      for (k = 0; k < count; k++) begin
         if (patterned) begin
            case (k % 4)
               0: tone = 16'h0000;
               1: tone = 16'hFFFF;
               2: tone = 16'h5555;
               default: tone = 16'hAAAA;
            endcase
            pixel_backlog.push_back('{tone, ~tone, tone, ~tone});
         end else begin
            pixel_backlog.push_back({$urandom, $urandom});
         end
      end
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      while (pixel_backlog.size() != 0 || req_valid || pending_routes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(posedge clock) begin : pixel_driver
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_route(offered_px);
            send_wait = send_burst ? 0 : $urandom_range(0, 8);
         end
         if (!req_valid || req_ready) begin
            if (send_wait > 0) begin
               send_wait = send_wait - 1;
               req_valid <= 1'b0;
            end else if (pixel_backlog.size() != 0) begin
               offered_px = pixel_backlog.pop_front();
               req_valid    <= 1'b1;
               req_red_in   <= offered_px.red;
               req_green_in <= offered_px.green;
               req_blue_in  <= offered_px.blue;
               req_alpha_in <= offered_px.alpha;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : result_monitor
      route_entry_t seen;
      route_entry_t want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out, rsp_region_mask};
            if (pending_routes.size() == 0) begin
               if (fault_count < 10)
                  $display("unexpected transaction: r %h g %h b %h a %h mask %b",
                           seen.px.red, seen.px.green, seen.px.blue, seen.px.alpha,
                           seen.mask);
               fault_count++;
            end else begin
               want = pending_routes.pop_front();
               if (seen !== want) begin
                  if (fault_count < 10)
                     $display({"transaction mismatch: expected r %h g %h b %h a %h mask %b,",
                               " got r %h g %h b %h a %h mask %b"},
                              want.px.red, want.px.green, want.px.blue, want.px.alpha,
                              want.mask, seen.px.red, seen.px.green, seen.px.blue,
                              seen.px.alpha, seen.mask);
                  fault_count++;
               end
            end
            recv_wait = recv_burst ? 0 : $urandom_range(0, 8);
         end
         if (recv_wait > 0) begin
            recv_wait = recv_wait - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : run_sequence
      int                     phase;
      int                     sent;
      int                     n;
      int                     xb;
      int                     yb;
      int                     i;
      region_type             r;
      logic [CSR_DATA_WIDTH-1:0] word;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // nothing configured: every pixel is dropped
      queue_pixels(2, 1'b1);
      drain_pipeline();

      // full-frame, carry past 16 bits, empty and single-pixel rectangles
      write_register(CSR_IMAGE_WIDTH, 64'd4);
      write_register(CSR_IMAGE_HEIGHT, 64'd3);
      write_register(CSR_REGION_COUNT, 64'd7);
      write_register(CSR_REGION_ZERO, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
      write_register(CSR_REGION_ONE, {16'hFFFF, 16'hFFFF, 16'd1, 16'd1});
      write_register(CSR_REGION_TWO, {16'd0, 16'd5, 16'd0, 16'd0});
      write_register(CSR_REGION_THREE, {16'd1, 16'd1, 16'd3, 16'd2});
      write_register(CSR_UNMAPPED, '1);
      queue_pixels(12, 1'b1);
      drain_pipeline();

      // zero width: column pinned, row advances every pixel
      write_register(CSR_IMAGE_WIDTH, 64'd0);
      write_register(CSR_REGION_COUNT, 64'd2);
      write_register(CSR_REGION_ZERO, {16'd1, 16'd1, 16'd0, 16'd1});
      queue_pixels(4, 1'b1);
      drain_pipeline();

      // zero height: row pinned
      write_register(CSR_IMAGE_WIDTH, 64'd5);
      write_register(CSR_IMAGE_HEIGHT, 64'd0);
      write_register(CSR_REGION_COUNT, 64'd1);
      write_register(CSR_REGION_ZERO, {16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
      queue_pixels(3, 1'b1);
      drain_pipeline();

      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         send_burst = ($urandom_range(0, 3) == 0);
         recv_burst = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) != 0) begin
            word = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: word[15:0] = 16'd0;
               1: word[15:0] = 16'hFFFF;
               2: word[15:0] = 16'($urandom);
               default: word[15:0] = 16'($urandom_range(1, 12));
            endcase
            write_register(CSR_IMAGE_WIDTH, word);
         end
         if ($urandom_range(0, 2) != 0) begin
            word = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: word[15:0] = 16'd0;
               1: word[15:0] = 16'hFFFF;
               2: word[15:0] = 16'($urandom);
               default: word[15:0] = 16'($urandom_range(1, 10));
            endcase
            write_register(CSR_IMAGE_HEIGHT, word);
         end
         if ($urandom_range(0, 2) != 0)
            write_register(CSR_REGION_COUNT, {$urandom, $urandom});
         xb = (frame_width == 0 || frame_width > 12) ? 12 : int'(frame_width);
         yb = (frame_height == 0 || frame_height > 10) ? 10 : int'(frame_height);
         for (i = 0; i < 4; i++) begin
            if ($urandom_range(0, 2) != 0) begin
               case ($urandom_range(0, 7))
                  0: r = {$urandom, $urandom};
                  1: begin
                     r.w = 16'hFFFF;
                     r.h = 16'($urandom_range(0, yb));
                     r.x = 16'($urandom_range(0, xb));
                     r.y = 16'($urandom_range(0, yb));
                  end
                  default: begin
                     r.w = 16'($urandom_range(0, xb));
                     r.h = 16'($urandom_range(0, yb));
                     r.x = 16'($urandom_range(0, xb));
                     r.y = 16'($urandom_range(0, yb));
                  end
               endcase
               write_register(CSR_INDEX_WIDTH'(CSR_REGION_ZERO + i), r);
            end
         end
         n = $urandom_range(10, 60);
         if (phase == 0 || $urandom_range(0, 4) == 0) begin
            // hold the stream until every routed pixel is back
            queue_pixels(n / 2, 1'b0);
            drain_pipeline();
            queue_pixels(n - n / 2, 1'b0);
         end else begin
            queue_pixels(n, 1'b0);
         end
         drain_pipeline();
         sent += n;
         phase++;
      end

      if (fault_count == 0 && pending_routes.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
